// File: hdl/tkpc_pkg.sv
// tkpc_pkg: shared types and constants for the touch key press classifier.
// Holds the phase and event codes, register indexes and reset defaults.
// Depends on nothing; used by touch_key_press_classifier.
`default_nettype none

package tkpc_pkg;

	// Fixed field widths
	localparam int unsigned MASK_W  = 8;
	localparam int unsigned KEY_W   = 3;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned SCAN_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Default number of touch channels
	localparam int unsigned CHANNELS_DEF = 8;

	// Register reset values
	localparam logic [TICK_W-1:0] STARTUP_HOLD_DEF = 16'd1000;
	localparam logic [SCAN_W-1:0] SCAN_PERIOD_DEF  = 8'd10;
	localparam logic [TICK_W-1:0] LONG_PRESS_DEF   = 16'd1000;
	localparam logic [TICK_W-1:0] REPEAT_DEF       = 16'd450;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STARTUP_HOLD = 2'd0,
		REG_SCAN_PERIOD  = 2'd1,
		REG_LONG_PRESS   = 2'd2,
		REG_REPEAT       = 2'd3
	} cfg_reg_t;

	// Press tracking phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_LONG    = 2'd2
	} phase_t;

	// Event codes on the result channel
	typedef enum logic [KIND_W-1:0] {
		EV_SHORT        = 2'd0,
		EV_LONG_START   = 2'd1,
		EV_REPEAT       = 2'd2,
		EV_LONG_RELEASE = 2'd3
	} event_t;

endpackage

`default_nettype wire

// File: hdl/touch_key_press_classifier.sv
// touch_key_press_classifier: turns per-millisecond touch masks into key events.
// Scan timing, priority encoding and the press phase machine in one pass.
// Depends on tkpc_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  input   | in_valid / in_ready  | touch_mask[7:0]
//  result  | out_valid / out_ready| key_index[2:0], event_kind[1:0]
//  config  | cfg_we (no wait)     | cfg_index[1:0], cfg_data[15:0]
//
// One tick transaction per cycle: an input register, one pass of logic that
// updates the countdowns and the phase, and a result register. A stalled
// result holds only the result register; a tick waiting behind it holds the
// input register, and input stalls only when both are full. Reset puts the
// scan countdown at the startup hold default; the startup hold register is
// only ever seen at reset.
`default_nettype none

module touch_key_press_classifier #(
	parameter int unsigned CHANNELS = tkpc_pkg::CHANNELS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [tkpc_pkg::MASK_W-1:0]         touch_mask,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [tkpc_pkg::KEY_W-1:0]          key_index,
	output logic [tkpc_pkg::KIND_W-1:0]         event_kind,
	input  wire                                 cfg_we,
	input  wire  [tkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [tkpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Only the channels that exist on the 8-bit mask take part
	localparam int unsigned NKEY = (CHANNELS < tkpc_pkg::MASK_W) ? CHANNELS
	                                                             : tkpc_pkg::MASK_W;

	// Configuration registers
	logic [tkpc_pkg::SCAN_W-1:0] scan_period_q;
	logic [tkpc_pkg::TICK_W-1:0] long_press_q;
	logic [tkpc_pkg::TICK_W-1:0] repeat_q;

	// Input stage
	logic                        v_s1;
	logic [tkpc_pkg::MASK_W-1:0] mask_s1;

	// Tracking state
	tkpc_pkg::phase_t            phase_q, phase_d;
	logic [tkpc_pkg::KEY_W-1:0]  held_q, held_d;
	logic [tkpc_pkg::TICK_W-1:0] scan_q, scan_d;
	logic [tkpc_pkg::TICK_W-1:0] wait_q, wait_d;

	// Pass logic
	logic                        adv;
	logic [tkpc_pkg::TICK_W-1:0] scan_dec, wait_dec;
	logic                        scan_now;
	logic                        present;
	logic [tkpc_pkg::KEY_W-1:0]  key;
	logic                        same;
	logic                        ev_valid;
	tkpc_pkg::event_t            ev_kind;

	// Move the input register forward when the result register can take it
	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	// Write configuration; the startup hold only matters at reset, where it
	// is back at its default, so index zero is taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= tkpc_pkg::SCAN_PERIOD_DEF;
			long_press_q  <= tkpc_pkg::LONG_PRESS_DEF;
			repeat_q      <= tkpc_pkg::REPEAT_DEF;
		end else if (cfg_we) begin
			unique case (tkpc_pkg::cfg_reg_t'(cfg_index))
				tkpc_pkg::REG_STARTUP_HOLD: ;
				tkpc_pkg::REG_SCAN_PERIOD:  scan_period_q <= cfg_data[tkpc_pkg::SCAN_W-1:0];
				tkpc_pkg::REG_LONG_PRESS:   long_press_q  <= cfg_data;
				tkpc_pkg::REG_REPEAT:       repeat_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture a tick transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mask_s1 <= touch_mask;
		end
	end

	// Drop both countdowns by one, stopping at zero
	assign scan_dec = (scan_q != '0) ? scan_q - 1'b1 : scan_q;
	assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
	assign scan_now = (scan_dec == '0);

	// Lowest touched channel wins
	always_comb begin
		present = 1'b0;
		key     = '0;
		for (int i = NKEY - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				present = 1'b1;
				key     = i[tkpc_pkg::KEY_W-1:0];
			end
		end
	end

	assign same = present && (key == held_q);

	// Next state
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		scan_d  = scan_dec;
		wait_d  = wait_dec;
		if (scan_now) begin
			scan_d = {{(tkpc_pkg::TICK_W-tkpc_pkg::SCAN_W){1'b0}}, scan_period_q};
			unique case (phase_q)
				tkpc_pkg::PH_IDLE: begin
					if (present) begin
						held_d  = key;
						wait_d  = long_press_q;
						phase_d = tkpc_pkg::PH_PRESSED;
					end
				end
				tkpc_pkg::PH_PRESSED: begin
					if (!same) begin
						phase_d = tkpc_pkg::PH_IDLE;
					end else if (wait_dec == '0) begin
						wait_d  = repeat_q;
						phase_d = tkpc_pkg::PH_LONG;
					end
				end
				tkpc_pkg::PH_LONG: begin
					if (!same) begin
						phase_d = tkpc_pkg::PH_IDLE;
					end else if (wait_dec == '0) begin
						wait_d = repeat_q;
					end
				end
				default: phase_d = tkpc_pkg::PH_IDLE;
			endcase
		end
	end

	// Event output
	always_comb begin
		ev_valid = 1'b0;
		ev_kind  = tkpc_pkg::EV_SHORT;
		if (scan_now) begin
			unique case (phase_q)
				tkpc_pkg::PH_PRESSED: begin
					if (!same) begin
						ev_valid = 1'b1;
						ev_kind  = tkpc_pkg::EV_SHORT;
					end else if (wait_dec == '0) begin
						ev_valid = 1'b1;
						ev_kind  = tkpc_pkg::EV_LONG_START;
					end
				end
				tkpc_pkg::PH_LONG: begin
					if (!same) begin
						ev_valid = 1'b1;
						ev_kind  = tkpc_pkg::EV_LONG_RELEASE;
					end else if (wait_dec == '0) begin
						ev_valid = 1'b1;
						ev_kind  = tkpc_pkg::EV_REPEAT;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the tracking state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tkpc_pkg::PH_IDLE;
			held_q  <= '0;
			scan_q  <= tkpc_pkg::STARTUP_HOLD_DEF;
			wait_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			scan_q  <= scan_d;
			wait_q  <= wait_d;
		end
	end

	// Result register: load on a pass, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ev_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ev_valid) begin
			key_index  <= held_q;
			event_kind <= ev_kind;
		end
	end

	// Checks
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_valid && (ev_kind == tkpc_pkg::EV_SHORT ||
		                     ev_kind == tkpc_pkg::EV_LONG_RELEASE))
		|=> (phase_q == tkpc_pkg::PH_IDLE))
		else $error("press end did not return to idle");

	a_long_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ev_valid && (ev_kind == tkpc_pkg::EV_LONG_START ||
		                     ev_kind == tkpc_pkg::EV_REPEAT))
		|=> (phase_q == tkpc_pkg::PH_LONG && wait_q == $past(repeat_q)))
		else $error("long hold event without repeat reload");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !adv)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: test/touch_key_press_classifier_tb.sv
// touch_key_press_classifier_tb: self-checking bench for the touch key press classifier.
// Drives tick transactions through random pacing, predicts key events and checks them.
// Depends on tkpc_pkg and touch_key_press_classifier.
`timescale 1ns / 100ps

module touch_key_press_classifier_tb;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned MAX_SHOWN    = 10;
	localparam int unsigned SETTLE       = 6;
	localparam int unsigned STARTUP_TICKS = 999;

	typedef logic [tkpc_pkg::MASK_W-1:0] mask_t;
	typedef logic [tkpc_pkg::TICK_W-1:0] tick_t;
	typedef logic [tkpc_pkg::SCAN_W-1:0] scan_t;
	typedef logic [tkpc_pkg::CFG_DATA_W-tkpc_pkg::SCAN_W-1:0] pad_t;

	typedef struct packed {
		logic [tkpc_pkg::KEY_W-1:0] key;
		tkpc_pkg::event_t           kind;
	} key_event_t;

	// DUT connections; the driven inputs are known from time zero
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [tkpc_pkg::MASK_W-1:0]     touch_mask = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [tkpc_pkg::KEY_W-1:0]      key_index;
	logic [tkpc_pkg::KIND_W-1:0]     event_kind;
	logic                            cfg_we = 1'b0;
	logic [tkpc_pkg::CFG_IDX_W-1:0]  cfg_index = tkpc_pkg::REG_STARTUP_HOLD;
	logic [tkpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted press tracker state and its copy of the registers
	logic [tkpc_pkg::TICK_W-1:0]     cfg_hold;
	logic [tkpc_pkg::SCAN_W-1:0]     cfg_scan;
	logic [tkpc_pkg::TICK_W-1:0]     cfg_long;
	logic [tkpc_pkg::TICK_W-1:0]     cfg_repeat;
	tkpc_pkg::phase_t                press_ph;
	logic [tkpc_pkg::KEY_W-1:0]      held;
	logic [tkpc_pkg::TICK_W-1:0]     scan_left;
	logic [tkpc_pkg::TICK_W-1:0]     wait_left;

	logic [tkpc_pkg::MASK_W-1:0]     tick_masks[$];
	key_event_t                      pending_events[$];

	int unsigned           cycle_count = 0;
	int unsigned           mismatches = 0;
	bit                    in_fire = 1'b0;
	bit                    idle_on = 1'b1;
	int unsigned           send_gap = 0;
	int unsigned           stall_left = 0;
	int unsigned           squeeze_left = 0;
	bit                    squeeze_req = 1'b0;
	bit                    squeeze_done = 1'b0;

	touch_key_press_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.touch_mask (touch_mask),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_index  (key_index),
		.event_kind (event_kind),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the tracker by one tick and queue the event it raises, if any
	function automatic void advance_tick(input logic [tkpc_pkg::MASK_W-1:0] mask);
		logic [tkpc_pkg::KEY_W-1:0] key;
		bit               present;
		bit               same;
		key_event_t       ev;
		int               ch;
		key = '0;
		present = 1'b0;
		if (scan_left != 0)
			scan_left--;
		if (wait_left != 0)
			wait_left--;
		if (scan_left != 0)
			return;
		scan_left = {{(tkpc_pkg::TICK_W-tkpc_pkg::SCAN_W){1'b0}}, cfg_scan};
		// lowest touched channel wins
		for (ch = int'(tkpc_pkg::CHANNELS_DEF) - 1; ch >= 0; ch--) begin
			if (mask[ch]) begin
				present = 1'b1;
				key = ch[tkpc_pkg::KEY_W-1:0];
			end
		end
		same = present && (key == held);
		ev.key = held;
		case (press_ph)
			tkpc_pkg::PH_IDLE: begin
				if (present) begin
					held = key;
					wait_left = cfg_long;
					press_ph = tkpc_pkg::PH_PRESSED;
				end
			end
			tkpc_pkg::PH_PRESSED: begin
				if (!same) begin
					press_ph = tkpc_pkg::PH_IDLE;
					ev.kind = tkpc_pkg::EV_SHORT;
					pending_events.push_back(ev);
				end else if (wait_left == 0) begin
					wait_left = cfg_repeat;
					press_ph = tkpc_pkg::PH_LONG;
					ev.kind = tkpc_pkg::EV_LONG_START;
					pending_events.push_back(ev);
				end
			end
			tkpc_pkg::PH_LONG: begin
				if (!same) begin
					press_ph = tkpc_pkg::PH_IDLE;
					ev.kind = tkpc_pkg::EV_LONG_RELEASE;
					pending_events.push_back(ev);
				end else if (wait_left == 0) begin
					wait_left = cfg_repeat;
					ev.kind = tkpc_pkg::EV_REPEAT;
					pending_events.push_back(ev);
				end
			end
			default: press_ph = tkpc_pkg::PH_IDLE;
		endcase
	endfunction

	// Count cycles, predict accepted ticks and check delivered events
	always @(posedge clk) begin : watch_results
		key_event_t want;
		cycle_count++;
		in_fire = in_valid && in_ready;
		if (in_fire)
			advance_tick(touch_mask);
		if (out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected event key %0d kind %0d",
						$time, key_index, event_kind);
			end else begin
				want = pending_events.pop_front();
				if (key_index !== want.key || event_kind !== want.kind) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: expected key %0d kind %0d, got key %0d kind %0d",
							$time, want.key, want.kind, key_index, event_kind);
				end
			end
		end
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer the next tick once the current transaction is taken, with random gaps
	always @(negedge clk) begin : drive_ticks
		logic                        nv;
		logic [tkpc_pkg::MASK_W-1:0] nm;
		nv = in_valid;
		nm = touch_mask;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_valid || in_fire) begin
			nv = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
			end else if (tick_masks.size() != 0) begin
				nv = 1'b1;
				nm = tick_masks.pop_front();
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 7);
			end
		end
		in_valid <= nv;
		touch_mask <= nm;
	end

	// Stall the result side in short bursts, and once for a long stretch
	always @(negedge clk) begin : take_results
		logic nr;
		nr = 1'b1;
		if (!arst_n) begin
			nr = 1'b0;
		end else if (squeeze_left != 0) begin
			nr = 1'b0;
			squeeze_left--;
		end else if (squeeze_req && !squeeze_done) begin
			squeeze_done = 1'b1;
			squeeze_left = 79;
			nr = 1'b0;
		end else if (stall_left != 0) begin
			nr = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			nr = 1'b0;
		end
		out_ready <= nr;
	end

	// Wait until every tick is in and every event is out, then let the pipe settle
	task automatic drain();
		do
			@(negedge clk);
		while (tick_masks.size() != 0 || in_valid || pending_events.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input tkpc_pkg::cfg_reg_t idx,
		input logic [tkpc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			tkpc_pkg::REG_STARTUP_HOLD: cfg_hold = val;
			tkpc_pkg::REG_SCAN_PERIOD:  cfg_scan = val[tkpc_pkg::SCAN_W-1:0];
			tkpc_pkg::REG_LONG_PRESS:   cfg_long = val;
			tkpc_pkg::REG_REPEAT:       cfg_repeat = val;
			default: ;
		endcase
	endtask

	// Write all four registers; junk in the unused upper byte of the scan period
	task automatic load_settings(input logic [tkpc_pkg::TICK_W-1:0] hold,
		input logic [tkpc_pkg::SCAN_W-1:0] scan,
		input logic [tkpc_pkg::TICK_W-1:0] lp, input logic [tkpc_pkg::TICK_W-1:0] rep);
		logic [tkpc_pkg::CFG_DATA_W-tkpc_pkg::SCAN_W-1:0] junk;
		junk = pad_t'($urandom_range(0, 255));
		write_reg(tkpc_pkg::REG_STARTUP_HOLD, hold);
		write_reg(tkpc_pkg::REG_SCAN_PERIOD, {junk, scan});
		write_reg(tkpc_pkg::REG_LONG_PRESS, lp);
		write_reg(tkpc_pkg::REG_REPEAT, rep);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_mask(input logic [tkpc_pkg::MASK_W-1:0] mask, input int unsigned len);
		repeat (len) tick_masks.push_back(mask);
	endtask

	// Hold one key: its bit set, random bits above it, none below
	task automatic queue_hold(input int unsigned key, input int unsigned len);
		logic [tkpc_pkg::MASK_W-1:0] one_hot;
		logic [tkpc_pkg::MASK_W-1:0] below;
		logic [tkpc_pkg::MASK_W-1:0] mask;
		one_hot = mask_t'(1);
		one_hot = one_hot << key;
		below = one_hot - 1'b1;
		repeat (len) begin
			mask = (mask_t'($urandom_range(0, 255)) & ~(below | one_hot)) | one_hot;
			tick_masks.push_back(mask);
		end
	endtask

	// Mostly key holds and releases of random length, some raw noise
	task automatic queue_random(input int unsigned n_ticks, input int unsigned max_run);
		int unsigned start;
		int unsigned len;
		int unsigned pick;
		start = tick_masks.size();
		while (tick_masks.size() - start < n_ticks) begin
			len = $urandom_range(1, max_run);
			pick = $urandom_range(0, 19);
			if (pick < 12)
				queue_hold($urandom_range(0, 7), len);
			else if (pick < 17)
				queue_mask('0, len);
			else
				repeat (len) tick_masks.push_back(mask_t'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		cfg_hold = tkpc_pkg::STARTUP_HOLD_DEF;
		cfg_scan = tkpc_pkg::SCAN_PERIOD_DEF;
		cfg_long = tkpc_pkg::LONG_PRESS_DEF;
		cfg_repeat = tkpc_pkg::REPEAT_DEF;
		press_ph = tkpc_pkg::PH_IDLE;
		held = '0;
		scan_left = tkpc_pkg::STARTUP_HOLD_DEF;
		wait_left = '0;

		// hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fast timing; the startup hold write is taken and dropped by the design
		load_settings(16'hFFFF, 8'd1, 16'd4, 16'd2);
		repeat (STARTUP_TICKS) tick_masks.push_back(mask_t'($urandom_range(0, 255)));
		// press and release key 7, then all channels touched at once
		queue_mask(8'h80, 2);
		queue_mask(8'h00, 2);
		queue_mask(8'hFF, 1);
		// hold key 0 through long start and repeats, then switch to key 1
		queue_hold(0, 8);
		queue_mask(8'h02, 2);
		queue_mask(8'h06, 1);
		// key change while only pressed ends it as a short press
		queue_mask(8'h04, 1);
		queue_mask(8'h00, 1);
		queue_random(60, 12);
		drain();

		// zero scan period and zero waits: scan and expire every tick
		load_settings(16'h0000, 8'd0, 16'd0, 16'd0);
		queue_random(40, 6);
		drain();

		// shortest legal timing; long receiver hold-off against a held key
		load_settings(tick_t'($urandom_range(0, 65535)), 8'd1, 16'd1, 16'd1);
		squeeze_req = 1'b1;
		queue_hold(5, 40);
		queue_random(40, 8);
		drain();

		// slow scan: few scans, the long press never matures
		load_settings(16'd1, 8'd20, 16'hFFFF, 16'hFFFF);
		queue_hold($urandom_range(0, 7), 25);
		queue_mask('0, 25);
		queue_hold($urandom_range(0, 7), 25);
		queue_hold($urandom_range(0, 7), 25);
		queue_mask('0, 25);
		drain();

		// instant long press with a repeat that never comes
		load_settings(tick_t'($urandom_range(0, 65535)), 8'd1, 16'd1, 16'hFFFF);
		queue_random(30, 20);
		drain();

		// unreachable long press under a fast scan
		load_settings(tick_t'($urandom_range(0, 65535)), 8'd2, 16'hFFFF, 16'd3);
		queue_random(30, 20);
		drain();

		// random small timings
		repeat (3) begin
			idle_on = ($urandom_range(0, 3) != 0);
			load_settings(tick_t'($urandom_range(0, 65535)), scan_t'($urandom_range(1, 4)),
				tick_t'($urandom_range(0, 30)), tick_t'($urandom_range(0, 15)));
			queue_random(30, 20);
			drain();
		end

		// closing stretch at full rate on both sides
		idle_on = 1'b0;
		load_settings(tkpc_pkg::STARTUP_HOLD_DEF, 8'd1, 16'd3, 16'd2);
		queue_random(40, 12);
		drain();

		if (mismatches == 0 && pending_events.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
